// ===== hw/rtl/aes256_block_cipher_defines.svh =====
// Shared assertion macros for the AES-256 block.
`ifndef AES256_BLOCK_CIPHER_DEFINES_SVH
`define AES256_BLOCK_CIPHER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define AES_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define AES_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hw/rtl/aes_pkg.sv =====
package aes_pkg;

    localparam int ROUND_COUNT = 14;
    localparam int KEY_ROWS    = ROUND_COUNT + 1;
    localparam int ROW_AW      = $clog2(KEY_ROWS);
    localparam int EXP_WORDS   = 4 * KEY_ROWS;
    localparam int EXP_AW      = $clog2(EXP_WORDS);

    localparam logic [ROW_AW-1:0] LAST_ROUND = ROW_AW'(ROUND_COUNT);
    localparam logic [EXP_AW-1:0] EXP_LAST   = EXP_AW'(EXP_WORDS - 1);

    localparam logic [1:0] CFG_KEY_WORD0 = 2'd0;
    localparam logic [1:0] CFG_KEY_WORD1 = 2'd1;
    localparam logic [1:0] CFG_KEY_WORD2 = 2'd2;
    localparam logic [1:0] CFG_KEY_WORD3 = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out_item;

    typedef struct packed {
        logic              cfg_we;
        logic              load;
        logic              exp_en;
        logic [EXP_AW-1:0] exp_idx;
        logic              rd_en;
        logic [ROW_AW-1:0] key_addr;
        logic              step_en;
        logic              step_first;
        logic              step_last;
        logic              dec;
        logic              out_load;
    } t_dp_cmd;

    typedef logic [7:0] t_byte_tab [256];

    localparam t_byte_tab SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Invert the forward table at elaboration.
    function automatic t_byte_tab make_inv_sbox();
        t_byte_tab t;
        for (int i = 0; i < 256; i++) begin
            t[SBOX[i]] = 8'(i);
        end
        return t;
    endfunction

    localparam t_byte_tab INV_SBOX = make_inv_sbox();

    localparam logic [7:0] RCON [8] = '{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = xtime(x);
        end
        return p;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Byte n of a block sits at bits [127-8n -: 8].
    function automatic logic [127:0] sub_bytes(input logic [127:0] x, input logic inv);
        logic [127:0] y;
        for (int i = 0; i < 16; i++) begin
            y[127-8*i -: 8] = inv ? INV_SBOX[x[127-8*i -: 8]] : SBOX[x[127-8*i -: 8]];
        end
        return y;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] x, input logic inv);
        logic [127:0] y;
        int           fs;
        int           is;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                fs = (c + r) % 4;
                is = (c - r + 4) % 4;
                y[127-8*(4*c+r) -: 8] = inv ? x[127-8*(4*is+r) -: 8] : x[127-8*(4*fs+r) -: 8];
            end
        end
        return y;
    endfunction

    function automatic logic [127:0] mix_core(input logic [127:0] x,
                                              input logic [3:0][7:0] m);
        logic [127:0] y;
        logic [7:0]   v;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                v = 8'h00;
                for (int k = 0; k < 4; k++) begin
                    v = v ^ gmul(x[127-8*(4*c+k) -: 8], m[(k - r + 4) % 4]);
                end
                y[127-8*(4*c+r) -: 8] = v;
            end
        end
        return y;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] x, input logic inv);
        logic [127:0] f;
        logic [127:0] b;
        f = mix_core(x, {8'd1, 8'd1, 8'd3, 8'd2});
        b = mix_core(x, {8'd9, 8'd13, 8'd11, 8'd14});
        return inv ? b : f;
    endfunction

endpackage

// ===== hw/rtl/aes_ram.sv =====
module aes_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/aes_ctrl.sv =====
module aes_ctrl import aes_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_dec,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  logic    i_cfg_valid,
    output logic    o_cfg_ready,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXPAND = 3'd1;
    localparam logic [2:0] S_FETCH  = 3'd2;
    localparam logic [2:0] S_ROUND  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [ROW_AW-1:0] r_step, n_step;
    logic [EXP_AW-1:0] r_exp, n_exp;
    logic              r_dec, n_dec;
    logic              r_out_valid, n_out_valid;

    logic              in_acc;
    logic              cfg_acc;
    logic              out_load;
    logic [ROW_AW-1:0] key_step;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_exp   = r_exp;
        n_dec   = r_dec;
        unique case (r_state)
            S_IDLE: begin
                if (cfg_acc) begin
                    n_state = S_EXPAND;
                    n_exp   = '0;
                end else if (in_acc) begin
                    n_state = S_FETCH;
                    n_dec   = i_in_dec;
                end
            end
            S_EXPAND: begin
                n_exp = r_exp + 1'b1;
                if (r_exp == EXP_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_FETCH: begin
                n_state = S_ROUND;
                n_step  = '0;
            end
            S_ROUND: begin
                n_step = r_step + 1'b1;
                if (r_step == LAST_ROUND) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_exp       <= '0;
            r_dec       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_exp       <= n_exp;
            r_dec       <= n_dec;
            r_out_valid <= n_out_valid;
        end
    end

    // Fetch the round key in the cycle before the round that uses it.
    assign key_step = (r_state == S_FETCH) ? '0 : r_step + 1'b1;

    always_comb begin
        o_cmd            = '0;
        o_cmd.cfg_we     = cfg_acc;
        o_cmd.load       = in_acc;
        o_cmd.exp_en     = (r_state == S_EXPAND);
        o_cmd.exp_idx    = r_exp;
        o_cmd.rd_en      = (r_state == S_FETCH) ||
                           ((r_state == S_ROUND) && (r_step != LAST_ROUND));
        o_cmd.key_addr   = r_dec ? LAST_ROUND - key_step : key_step;
        o_cmd.step_en    = (r_state == S_ROUND);
        o_cmd.step_first = (r_step == '0);
        o_cmd.step_last  = (r_step == LAST_ROUND);
        o_cmd.dec        = r_dec;
        o_cmd.out_load   = out_load;
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/aes_dp.sv =====
module aes_dp import aes_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  t_in_item    i_in_data,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output t_out_item   o_out_data
);

    logic [63:0]  r_key [4];
    logic [31:0]  r_win [8];
    logic [127:0] r_state, n_state;
    t_out_item    r_out;

    logic [31:0]  key_word;
    logic [31:0]  tmp_word;
    logic [31:0]  new_word;
    logic         row_we;
    logic [127:0] key_row;
    logic [127:0] enc_t;
    logic [127:0] dec_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_key[i] <= '0;
            end
        end else if (i_cmd.cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_WORD0: r_key[0] <= i_cfg_data;
                CFG_KEY_WORD1: r_key[1] <= i_cfg_data;
                CFG_KEY_WORD2: r_key[2] <= i_cfg_data;
                CFG_KEY_WORD3: r_key[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Key schedule: one word per cycle, last eight words kept in a window.
    assign key_word = i_cmd.exp_idx[0] ? r_key[i_cmd.exp_idx[2:1]][31:0]
                                       : r_key[i_cmd.exp_idx[2:1]][63:32];

    always_comb begin
        tmp_word = r_win[7];
        if (i_cmd.exp_idx[2:0] == 3'd0) begin
            tmp_word = sub_word({r_win[7][23:0], r_win[7][31:24]}) ^
                       {RCON[i_cmd.exp_idx[5:3]], 24'h000000};
        end else if (i_cmd.exp_idx[2:0] == 3'd4) begin
            tmp_word = sub_word(r_win[7]);
        end
        new_word = (i_cmd.exp_idx < EXP_AW'(8)) ? key_word : (r_win[0] ^ tmp_word);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exp_en) begin
            for (int i = 0; i < 7; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[7] <= new_word;
        end
    end

    // Write a full round key once its fourth word is ready.
    assign row_we = i_cmd.exp_en && (i_cmd.exp_idx[1:0] == 2'b11);

    aes_ram #(
        .WIDTH (128),
        .DEPTH (KEY_ROWS)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (row_we),
        .i_wr_addr (i_cmd.exp_idx[EXP_AW-1:2]),
        .i_wr_data ({r_win[5], r_win[6], r_win[7], new_word}),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_cmd.key_addr),
        .o_rd_data (key_row)
    );

    always_comb begin
        enc_t = shift_rows(sub_bytes(r_state, 1'b0), 1'b0);
        if (!i_cmd.step_last) begin
            enc_t = mix_columns(enc_t, 1'b0);
        end
        enc_t = enc_t ^ key_row;

        dec_t = sub_bytes(shift_rows(r_state, 1'b1), 1'b1) ^ key_row;
        if (!i_cmd.step_last) begin
            dec_t = mix_columns(dec_t, 1'b1);
        end

        if (i_cmd.step_first) begin
            n_state = r_state ^ key_row;
        end else begin
            n_state = i_cmd.dec ? dec_t : enc_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_state <= {i_in_data.block_high, i_in_data.block_low};
        end else if (i_cmd.step_en) begin
            r_state <= n_state;
        end
        if (i_cmd.out_load) begin
            r_out.result_high <= r_state[127:64];
            r_out.result_low  <= r_state[63:0];
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== hw/rtl/aes256_block_cipher.sv =====
// AES-256 encrypt/decrypt engine, one 128-bit block per transaction. Load the
// key through the four 64-bit key registers (index 0 holds key bytes 0..7);
// every key register write re-runs the key schedule, which makes all 60
// round-key words, one per cycle, while both input and config channels are
// held off. A block runs through one round unit, one round per cycle: a key
// fetch, the initial key add plus 14 rounds, and a load of the output
// register, which waits while an earlier result is still untaken. A new block
// is taken only once the last one has gone to the output register. The pace
// is set by the round unit and the single-read round-key store. The result
// stays in its output register until taken; results are undefined if a
// block is sent before any key register was written.
module aes256_block_cipher import aes_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_dp_cmd cmd;

    aes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_dec    (i_in_data.req_type),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd)
    );

    aes_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== hw/rtl/aes_chk.sv =====
`include "aes256_block_cipher_defines.svh"

module aes_chk import aes_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_item   o_out_data,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready
);

    // A waiting result must hold.
    `AES_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result dropped or changed while stalled")

    // A block in flight blocks the next one.
    `AES_ASSERT_NEXT(a_in_busy, i_in_valid && o_in_ready, !o_in_ready, "input taken during block processing")

    // No key write while a block is in flight.
    `AES_ASSERT_NEXT(a_cfg_busy, i_in_valid && o_in_ready, !o_cfg_ready, "key write open during block processing")

    // Key expansion blocks input and key writes.
    `AES_ASSERT_NEXT(a_exp_busy, i_cfg_valid && o_cfg_ready, !o_in_ready && !o_cfg_ready, "channel open during key expansion")

    // Input and key write never complete together.
    `AES_ASSERT_NOW(a_one_acc, i_cfg_valid && o_cfg_ready, !(i_in_valid && o_in_ready), "input and key write in same cycle")

endmodule

bind aes256_block_cipher aes_chk u_chk (.*);
